// ----- hdl/ssr_pkg.sv -----
// Shared types and constants for the stepper speed ramp and step-timer block.
package ssr_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned FREQ_W  = 19;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CMP_W   = 15;
  localparam int unsigned OUT_W   = 88;

  localparam logic [WORD_W-1:0]  SEC_PER_MIN = 32'd60;
  localparam logic [FREQ_W-1:0]  FREQ_LIMIT  = 19'h7FFFF;
  localparam logic [RATIO_W-1:0] RATIO_LIMIT = 17'h10000;

  // Reciprocal of 60: exact floor for any product below the saturation point,
  // which stays under 2^25. 35791395 * 60 exceeds 2^31 by 52, below 2^(31-25).
  localparam int unsigned        FREQ_IN_W     = 25;
  localparam int unsigned        FREQ_RECIP_W  = 26;
  localparam int unsigned        FREQ_SHIFT    = 31;
  localparam logic [FREQ_RECIP_W-1:0] FREQ_RECIP = 26'd35791395;
  // 60 * (FREQ_LIMIT + 1): products at or above this saturate the frequency
  localparam logic [WORD_W-1:0]  FREQ_SAT_PROD = 32'd31457280;

  localparam logic CFG_ACCEL_STEP = 1'b0;
  localparam logic CFG_CLOCK_HZ   = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_FREQ,
    ST_CNT_GO,
    ST_CNT_WAIT,
    ST_RAT_MUL,
    ST_RAT,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_FINISH
  } state_t;

  // Which quotient is being formed
  typedef enum logic [1:0] {
    DS_FREQ,
    DS_COUNTS,
    DS_RATIO,
    DS_SCALE
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul;
    logic     div_start;
    logic     capture;
    div_sel_t sel;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic freq_zero;
    logic quo_big;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- hdl/ssr_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ssr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ssr_pkg::WORD_W-1:0] dividend,
  input  logic [ssr_pkg::WORD_W-1:0] divisor,
  output logic [ssr_pkg::WORD_W-1:0] quotient,
  output logic                       done
);
  import ssr_pkg::*;

  localparam int unsigned STEP_W = $clog2(WORD_W);

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W+1:0] trial;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, den_r};
    if (!trial[WORD_W+1]) begin
      rem_nxt = trial[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
    end
  end

  // Iterate control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- hdl/ssr_ctrl.sv -----
// Sequencer for ramp, multiply and the chain of divisions per request.
module ssr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ssr_pkg::ctrl_sts_t sts,
  output ssr_pkg::ctrl_cmd_t cmd
);
  import ssr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_FREQ;
      ST_FREQ:      state_nxt = sts.freq_zero ? ST_FINISH : ST_CNT_GO;
      ST_CNT_GO:    state_nxt = ST_CNT_WAIT;
      ST_CNT_WAIT:  begin
        if (sts.div_done) state_nxt = sts.quo_big ? ST_RAT_MUL : ST_FINISH;
      end
      ST_RAT_MUL:   state_nxt = ST_RAT;
      ST_RAT:       state_nxt = ST_SCL_GO;
      ST_SCL_GO:    state_nxt = ST_SCL_WAIT;
      ST_SCL_WAIT:  if (sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH:    if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd       = '0;
    cmd.sel   = DS_FREQ;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.sel = DS_FREQ;
      end
      ST_FREQ: begin
        cmd.capture = 1'b1;
        cmd.sel     = DS_FREQ;
      end
      ST_CNT_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = DS_COUNTS;
      end
      ST_CNT_WAIT: begin
        cmd.capture = sts.div_done;
        cmd.sel     = DS_COUNTS;
      end
      ST_RAT_MUL: begin
        cmd.mul = 1'b1;
        cmd.sel = DS_RATIO;
      end
      ST_RAT: begin
        cmd.capture = 1'b1;
        cmd.sel     = DS_RATIO;
      end
      ST_SCL_GO: begin
        cmd.div_start = 1'b1;
        cmd.sel       = DS_SCALE;
      end
      ST_SCL_WAIT: begin
        cmd.capture = sts.div_done;
        cmd.sel     = DS_SCALE;
      end
      ST_FINISH:    cmd.load_out = sts.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ----- hdl/ssr_dpath.sv -----
// Datapath: config registers, speed ramp, multipliers, shared divider, result register.
module ssr_dpath #(
  parameter int unsigned STEPS_PER_REV = 400,
  parameter int unsigned TIMER_MAX     = 65535
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ssr_pkg::WORD_W-1:0]   cfg_data,
  input  logic [ssr_pkg::SPEED_W-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ssr_pkg::OUT_W-1:0]    out_tdata,
  output logic                         out_tuser,
  input  ssr_pkg::ctrl_cmd_t           cmd,
  output ssr_pkg::ctrl_sts_t           sts
);
  import ssr_pkg::*;

  localparam logic [WORD_W-1:0]  TMAX_W = WORD_W'(TIMER_MAX);
  localparam logic [SPEED_W-1:0] SPR_W  = SPEED_W'(STEPS_PER_REV);

  // Reciprocal of TIMER_MAX: ceil(2^k / TIMER_MAX) with k = 32 + ceil(log2 TIMER_MAX)
  // gives the exact floor for every 32-bit counts value; it fits in 33 bits.
  localparam int unsigned RAT_SHIFT    = WORD_W + $clog2(TIMER_MAX);
  localparam logic [63:0] RAT_RECIP    = ((64'd1 << RAT_SHIFT) + 64'(TIMER_MAX) - 64'd1)
                                         / 64'(TIMER_MAX);
  localparam logic [15:0] RAT_RECIP_LO = RAT_RECIP[15:0];
  localparam logic [16:0] RAT_RECIP_HI = RAT_RECIP[32:16];

  logic [SPEED_W-1:0] accel_r;
  logic [WORD_W-1:0]  clock_r;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [WORD_W-1:0]  prod_r;
  logic [47:0]        rat_lo_r;
  logic [48:0]        rat_hi_r;
  logic [FREQ_W-1:0]  freq_r;
  logic [WORD_W-1:0]  counts_r;
  logic [RATIO_W-1:0] ratio_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_stop_r;

  logic [WORD_W-1:0]  div_dividend, div_divisor, quo;
  logic               div_done;
  logic [SPEED_W:0]   up_sum;
  logic [SPEED_W-1:0] down_gap;
  logic [FREQ_IN_W+FREQ_RECIP_W-1:0] freq_prod;
  logic [FREQ_W-1:0]  freq_calc;
  logic [64:0]        rat_sum;
  logic [64:0]        rat_quo;
  logic [RATIO_W-1:0] ratio_calc;
  logic [WORD_W-1:0]  counts_fix;
  logic [CNT_W-1:0]   reload;
  logic [CNT_W-1:0]   prescale;
  logic [CMP_W-1:0]   compare;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= 16'd1;
      clock_r <= 32'd84000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEL_STEP: accel_r <= cfg_data[SPEED_W-1:0];
        CFG_CLOCK_HZ:   clock_r <= cfg_data;
        default:        accel_r <= accel_r;
      endcase
    end
  end

  // Move the kept speed toward the target, clamp at the target
  always_comb begin
    up_sum    = {1'b0, speed_r} + {1'b0, accel_r};
    down_gap  = speed_r - in_tdata;
    speed_nxt = speed_r;
    if (speed_r < in_tdata) begin
      speed_nxt = (up_sum > {1'b0, in_tdata}) ? in_tdata : up_sum[SPEED_W-1:0];
    end else if (speed_r > in_tdata) begin
      speed_nxt = (down_gap <= accel_r) ? in_tdata : speed_r - accel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (cmd.accept) begin
      speed_r <= speed_nxt;
    end
  end

  // Speed times steps per revolution, or counts times the reciprocal of TIMER_MAX
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (cmd.sel == DS_RATIO) begin
        rat_lo_r <= counts_r * RAT_RECIP_LO;
        rat_hi_r <= counts_r * RAT_RECIP_HI;
      end else begin
        prod_r <= speed_r * SPR_W;
      end
    end
  end

  // Quotients by the constants 60 and TIMER_MAX through reciprocal products
  always_comb begin
    freq_prod  = prod_r[FREQ_IN_W-1:0] * FREQ_RECIP;
    freq_calc  = (prod_r >= FREQ_SAT_PROD) ? FREQ_LIMIT
                                           : freq_prod[FREQ_SHIFT+FREQ_W-1:FREQ_SHIFT];
    rat_sum    = {rat_hi_r, 16'b0} + {17'b0, rat_lo_r};
    rat_quo    = rat_sum >> RAT_SHIFT;
    ratio_calc = (rat_quo >= 65'(RATIO_LIMIT)) ? RATIO_LIMIT
                                               : rat_quo[RATIO_W-1:0] + 1'b1;
  end

  // Divider operands
  always_comb begin
    div_dividend = counts_r;
    div_divisor  = {{(WORD_W-RATIO_W){1'b0}}, ratio_r};
    if (cmd.sel == DS_COUNTS) begin
      div_dividend = clock_r;
      div_divisor  = {{(WORD_W-FREQ_W){1'b0}}, freq_r};
    end
  end

  ssr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .done     (div_done)
  );

  // Capture quotients with their saturation
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      freq_r   <= '0;
      ratio_r  <= RATIO_W'(1);
      counts_r <= '0;
    end else if (cmd.capture) begin
      unique case (cmd.sel)
        DS_FREQ: begin
          freq_r <= freq_calc;
        end
        DS_COUNTS: begin
          counts_r <= quo;
          ratio_r  <= RATIO_W'(1);
        end
        DS_RATIO: begin
          ratio_r <= ratio_calc;
        end
        DS_SCALE: begin
          counts_r <= (quo > TMAX_W) ? TMAX_W : quo;
        end
        default: freq_r <= freq_r;
      endcase
    end
  end

  // Timer fields from counts and ratio
  always_comb begin
    counts_fix = (counts_r == '0) ? WORD_W'(1) : counts_r;
    reload     = CNT_W'(counts_fix - 1'b1);
    prescale   = CNT_W'(ratio_r - 1'b1);
    compare    = reload[CNT_W-1:1];
  end

  // Result register, refilled when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_stop_r <= (freq_r == '0);
      if (freq_r == '0) begin
        out_data_r <= {6'b0, {(CMP_W+2*CNT_W){1'b0}}, freq_r, speed_r};
      end else begin
        out_data_r <= {6'b0, compare, prescale, reload, freq_r, speed_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stop_r;

  // Status back to the controller
  always_comb begin
    sts.div_done  = div_done;
    sts.freq_zero = (prod_r < SEC_PER_MIN);
    sts.quo_big   = (quo > TMAX_W);
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

// ----- hdl/stepper_speed_ramp_pwm_timer.sv -----
// Stepper speed ramp with step-timer reload, prescaler and compare calculation.
// Each request carries a target speed in rpm; the kept speed moves toward it by at most
// accel_step and clamps at the target. The result gives the ramped speed, the step
// frequency (speed * STEPS_PER_REV / 60, saturated at 524287), and the reload,
// prescaler and half-period compare values for a timer counting to TIMER_MAX; a zero
// frequency sets the stopped flag in tuser and zeroes the timer fields. One request is
// worked on at a time. A single shared 32-bit divider yields one quotient bit per cycle
// and runs up to two divisions in turn; the divisions by 60 and by TIMER_MAX use
// reciprocal products. A new request is taken while the previous result still waits
// in the output register. Configuration must be written only while no request is in
// flight; the block itself does not enforce this.
module stepper_speed_ramp_pwm_timer #(
  parameter int unsigned STEPS_PER_REV = 400,
  parameter int unsigned TIMER_MAX     = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration: index 0 accel_step, index 1 clock_hz
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ssr_pkg::WORD_W-1:0]  cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] target_speed
  input  logic [ssr_pkg::SPEED_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] current_speed, [34:16] step_freq, [50:35] reload_value,
  // [66:51] prescale_value, [81:67] compare_value, [87:82] zero
  output logic [ssr_pkg::OUT_W-1:0]   out_tdata,
  // [0] stopped
  output logic                        out_tuser
);
  import ssr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssr_dpath #(
    .STEPS_PER_REV (STEPS_PER_REV),
    .TIMER_MAX     (TIMER_MAX)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a request is in flight");

  // Stopped result carries zero timer fields
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[81:35] == '0 && out_tdata[34:16] == '0)
    else $error("stopped result with nonzero timer fields");

  // Running result has a nonzero frequency
  a_running_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[34:16] != '0)
    else $error("running result with zero step frequency");

  // Divider is only started from a start state, never while capturing
  a_div_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.div_start && (cmd.capture || cmd.accept || cmd.load_out)))
    else $error("divider start overlaps another command");

endmodule
